@@ rtl/positional_insert_remove_sequence_core_assert.svh @@
// Assertion macros used by the core RTL file
`ifndef POSITIONAL_INSERT_REMOVE_SEQUENCE_CORE_ASSERT_SVH
`define POSITIONAL_INSERT_REMOVE_SEQUENCE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PIRS_ASSERT_SAME(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define PIRS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define PIRS_ASSERT_SAME(lbl, clk, rst, pre, post)
`define PIRS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

@@ rtl/pirs_pkg.sv @@
`default_nettype none

package pirs_pkg;

   localparam int POS_W     = 5;
   localparam int ITEM_W    = 32;
   localparam int LEN_W     = 5;
   localparam int OP_W      = 2;
   localparam int ST_W      = 2;
   localparam int DEPTH_DEF = 16;

   typedef enum logic [OP_W-1:0] {
      OP_READ   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [POS_W-1:0]  pos;
      logic [ITEM_W-1:0] value;
   } ctl_type;

endpackage

`default_nettype wire

@@ rtl/pirs_cell.sv @@
`default_nettype none

module pirs_cell
   import pirs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire ctl_type           ctl,
   input  wire logic [ITEM_W-1:0] prev_item,
   input  wire logic [ITEM_W-1:0] next_item,
   output logic      [ITEM_W-1:0] item,
   output logic                   hit
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int CmpW = (POS_W > CntW) ? POS_W : CntW;
   localparam logic [CmpW-1:0] IdxC = CmpW'(INDEX);

   logic [ITEM_W-1:0] data_ff;
   logic [ITEM_W-1:0] data_in;
   logic [CmpW-1:0]   pos_ext;

   assign pos_ext = CmpW'(ctl.pos);
   assign item    = data_ff;
   assign hit     = (pos_ext == IdxC);

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (pos_ext == IdxC) begin
            data_in = ctl.value;
         end else if (IdxC > pos_ext) begin
            data_in = prev_item;
         end
      end
      if (ctl.rem && (IdxC >= pos_ext)) begin
         data_in = next_item;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

@@ rtl/positional_insert_remove_sequence_core.sv @@
// Latency: a result is valid in the cycle after its request transfer.
// Throughput: one request per cycle; the cells from the position on shift together, and a
// request transfers in any cycle where no result waits or the waiting one transfers.
// Reset: synchronous, clears the item count and the output valid; stored
// items are undefined until written.
`default_nettype none

`include "positional_insert_remove_sequence_core_assert.svh"

module positional_insert_remove_sequence_core
   import pirs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // position[4:0], value[36:5], zeros
   input  wire logic [1:0]  req_tuser,  // operation[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata   // item_out[31:0], length_now[36:32],
                                        // status[38:37], zeros
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int CmpW = (POS_W > CntW) ? POS_W : CntW;

   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;
   logic              rsp_tvalid_ff;
   logic              rsp_tvalid_in;
   logic [ITEM_W-1:0] rsp_item_ff;
   logic [ITEM_W-1:0] rsp_item_in;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic [LEN_W-1:0]  rsp_len_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;

   op_type            op;
   logic [POS_W-1:0]  pos;
   logic [ITEM_W-1:0] value;
   logic [CmpW-1:0]   pos_ext;
   logic [CmpW-1:0]   count_ext;
   logic [CmpW-1:0]   len_ext;
   logic              req_fire;
   logic              full;
   logic              read_ok;
   logic              ins_ok;
   logic              rem_ok;
   status_type        status;
   ctl_type           ctl;
   logic [ITEM_W-1:0] sel_item;

   logic [ITEM_W-1:0] cell_item [DEPTH];
   logic              cell_hit  [DEPTH];

   assign op        = op_type'(req_tuser);
   assign pos       = req_tdata[POS_W-1:0];
   assign value     = req_tdata[POS_W+ITEM_W-1:POS_W];
   assign pos_ext   = CmpW'(pos);
   assign count_ext = CmpW'(count_ff);
   assign full      = (count_ff == CntW'(DEPTH));

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      read_ok = 1'b0;
      ins_ok  = 1'b0;
      rem_ok  = 1'b0;
      status  = ST_RANGE;
      case (op)
         OP_READ: begin
            read_ok = (pos_ext < count_ext);
            status  = read_ok ? ST_OK : ST_RANGE;
         end
         OP_INSERT: begin
            if (pos_ext > count_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ins_ok = 1'b1;
               status = ST_OK;
            end
         end
         OP_REMOVE: begin
            rem_ok = (pos_ext < count_ext);
            status = rem_ok ? ST_OK : ST_RANGE;
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   always_comb begin
      ctl.ins   = req_fire && ins_ok;
      ctl.rem   = req_fire && rem_ok;
      ctl.pos   = pos;
      ctl.value = value;
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [ITEM_W-1:0] prev_item;
         logic [ITEM_W-1:0] next_item;
         if (gi == 0) begin : g_first
            assign prev_item = value;
         end else begin : g_mid
            assign prev_item = cell_item[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign next_item = cell_item[gi];
         end else begin : g_inner
            assign next_item = cell_item[gi+1];
         end
         pirs_cell #(
            .DEPTH (DEPTH),
            .INDEX (gi)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .prev_item (prev_item),
            .next_item (next_item),
            .item      (cell_item[gi]),
            .hit       (cell_hit[gi])
         );
      end
   endgenerate

   always_comb begin
      sel_item = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_hit[i]) begin
            sel_item = sel_item | cell_item[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.rem) begin
         count_in = count_ff - 1'b1;
      end
      len_ext       = CmpW'(count_in);
      rsp_len_in    = len_ext[LEN_W-1:0];
      rsp_item_in   = (read_ok || rem_ok) ? sel_item : '0;
      rsp_status_in = status;
      rsp_tvalid_in = req_fire || (rsp_tvalid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_item_ff   <= rsp_item_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_status_ff, rsp_len_ff, rsp_item_ff};

   `PIRS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(DEPTH))
   `PIRS_ASSERT_NEXT(a_insert_grows, clock, reset, ctl.ins,
                     count_ff == $past(count_ff) + 1'b1)
   `PIRS_ASSERT_NEXT(a_full_refusal, clock, reset, req_fire && status == ST_FULL,
                     count_ff == CntW'(DEPTH))
   `PIRS_ASSERT_NEXT(a_result_follows, clock, reset, req_fire, rsp_tvalid_ff)

endmodule

`default_nettype wire
